FILE: rtl/mr3k_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mr3k_pkg
// Shared types and constants of the MIPS I integer core: transaction
// payloads, register file write port, opcodes and fixed addresses.
// ----------------------------------------------------------------------------
package mr3k_pkg;

    typedef struct packed {
        logic        cmd;
        logic [31:0] instr_word;
        logic [31:0] read_data;
    } item_t;

    typedef struct packed {
        logic [31:0] fetch_addr;
        logic [1:0]  req_kind;
        logic [31:0] mem_addr;
        logic [1:0]  mem_size;
        logic [31:0] write_data;
        logic        exception_taken;
        logic [4:0]  exception_code;
        logic        illegal;
    } result_t;

    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } rf_wr_t;

    localparam logic [31:0] FILL_WORD  = 32'hFAAF_FAAF;
    localparam logic [31:0] BOOT_PC    = 32'hBFC0_0000;
    localparam logic [31:0] ROM_VECTOR = 32'hBFC0_0180;
    localparam logic [31:0] RAM_VECTOR = 32'h8000_0080;

    localparam int ISOLATE_POS = 16;
    localparam int BEV_POS     = 22;

    localparam logic CMD_INSTR = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [1:0] LD_LB  = 2'd0;
    localparam logic [1:0] LD_LBU = 2'd1;
    localparam logic [1:0] LD_LW  = 2'd2;

    localparam logic [4:0] EXC_ADEL = 5'd4;
    localparam logic [4:0] EXC_ADES = 5'd5;
    localparam logic [4:0] EXC_SYS  = 5'd8;
    localparam logic [4:0] EXC_OV   = 5'd12;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;
    localparam logic [5:0] FN_RFE     = 6'h10;

    localparam logic [4:0] RI_BLTZ    = 5'h00;
    localparam logic [4:0] RI_BGEZ    = 5'h01;
    localparam logic [4:0] RI_BLTZAL  = 5'h10;
    localparam logic [4:0] RI_BGEZAL  = 5'h11;

    localparam logic [4:0] CP_MF      = 5'h00;
    localparam logic [4:0] CP_MT      = 5'h04;
    localparam logic [4:0] CP_CO      = 5'h10;

    localparam logic [4:0] C0_STATUS  = 5'd12;
    localparam logic [4:0] C0_CAUSE   = 5'd13;
    localparam logic [4:0] C0_EPC     = 5'd14;

    localparam logic [4:0] LINK_REG   = 5'd31;

    function automatic logic c0_debug(input logic [4:0] r);
        return (r == 5'd3) || (r == 5'd5) || (r == 5'd6) || (r == 5'd7) ||
               (r == 5'd9) || (r == 5'd11);
    endfunction

endpackage

FILE: rtl/mr3k_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mr3k_regfile
// 32 x 32 general register file: one write port, two registered read ports.
// Entries never written read as the fill word; entry zero reads as zero.
// ----------------------------------------------------------------------------
module mr3k_regfile (
    input  logic             clk,
    input  logic             rst_n,
    input  mr3k_pkg::rf_wr_t wr,
    input  logic [4:0]       raddr_a,
    input  logic [4:0]       raddr_b,
    output logic [31:0]      rdata_a,
    output logic [31:0]      rdata_b
);

    logic [31:0] mem [32];
    logic [31:0] written_reg;
    logic [31:0] data_a_reg;
    logic [31:0] data_b_reg;
    logic        ok_a_reg;
    logic        ok_b_reg;
    logic        zero_a_reg;
    logic        zero_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        data_a_reg <= mem[raddr_a];
        data_b_reg <= mem[raddr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            ok_a_reg    <= 1'b0;
            ok_b_reg    <= 1'b0;
            zero_a_reg  <= 1'b1;
            zero_b_reg  <= 1'b1;
        end
        else
        begin
            if (wr.en)
            begin
                written_reg[wr.addr] <= 1'b1;
            end
            ok_a_reg   <= written_reg[raddr_a];
            ok_b_reg   <= written_reg[raddr_b];
            zero_a_reg <= (raddr_a == 5'd0);
            zero_b_reg <= (raddr_b == 5'd0);
        end
    end

    assign rdata_a = zero_a_reg ? 32'd0 : (ok_a_reg ? data_a_reg : mr3k_pkg::FILL_WORD);
    assign rdata_b = zero_b_reg ? 32'd0 : (ok_b_reg ? data_b_reg : mr3k_pkg::FILL_WORD);

endmodule

FILE: rtl/mr3k_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mr3k_divider
// Restoring radix-2 divider, one quotient bit per cycle, signed or unsigned.
// Divisor must be nonzero; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module mr3k_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        sgn,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic [32:0] shifted;
    logic [33:0] diff;

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_q_reg <= sgn & (dividend[31] ^ divisor[31]);
            neg_r_reg <= sgn & dividend[31];
            quo_reg   <= (sgn & dividend[31]) ? (32'd0 - dividend) : dividend;
            den_reg   <= (sgn & divisor[31]) ? (32'd0 - divisor) : divisor;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = neg_q_reg ? (32'd0 - quo_reg) : quo_reg;
    assign remainder = neg_r_reg ? (32'd0 - rem_reg) : rem_reg;

endmodule

FILE: rtl/mips_r3000_integer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_r3000_integer_core
// MIPS I integer core, one instruction word or load return per transaction.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+---------------------
//   item     | in  | item_valid/item_stall  | mr3k_pkg::item_t
//   result   | out | result_valid/result_stall | mr3k_pkg::result_t
//
// Register operands come from a synchronous register file: accept, read,
// execute, then retire aged delayed loads one at a time (skipped after a
// load issue or a fetch address error), then the result. DIV/DIVU wait on
// the iterative divider first. Ignored transactions go straight to the result.
// Reset is asynchronous; no clearing pass (register file uses valid bits).
// A new item is accepted while the previous result waits on result_stall.
// ----------------------------------------------------------------------------
module mips_r3000_integer_core #(
    parameter int LOAD_SLOTS = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  mr3k_pkg::item_t     item,
    output logic                result_valid,
    input  logic                result_stall,
    output mr3k_pkg::result_t   result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIV,
        ST_AGE,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    mr3k_pkg::item_t     ir_reg, ir_next;
    mr3k_pkg::result_t   res_reg, res_next;
    mr3k_pkg::result_t   out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [31:0] hi_reg, hi_next, lo_reg, lo_next;
    logic [31:0] pc_now_reg, pc_now_next, pc_after_reg, pc_after_next;
    logic [31:0] exec_pc_reg, exec_pc_next;
    logic        br_reg, br_next, dly_reg, dly_next;
    logic [31:0] status_reg, status_next, cause_reg, cause_next, epc_reg, epc_next;
    logic        wait_reg, wait_next;
    logic [1:0]  wait_kind_reg, wait_kind_next;
    logic [4:0]  wait_tgt_reg, wait_tgt_next;

    logic [4:0]  ld_tgt_reg  [LOAD_SLOTS];
    logic [31:0] ld_val_reg  [LOAD_SLOTS];
    logic        ld_age_reg  [LOAD_SLOTS];
    logic        ld_vld_reg  [LOAD_SLOTS];
    logic [4:0]  ld_tgt_next [LOAD_SLOTS];
    logic [31:0] ld_val_next [LOAD_SLOTS];
    logic        ld_age_next [LOAD_SLOTS];
    logic        ld_vld_next [LOAD_SLOTS];

    mr3k_pkg::rf_wr_t rf_wr;
    logic [31:0]      rf_a, rf_b;
    logic             div_start, div_sgn, div_done;
    logic [31:0]      div_q, div_r;

    mr3k_regfile u_rf (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (rf_wr),
        .raddr_a (ir_reg.instr_word[25:21]),
        .raddr_b (ir_reg.instr_word[20:16]),
        .rdata_a (rf_a),
        .rdata_b (rf_b)
    );

    mr3k_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .sgn       (div_sgn),
        .dividend  (rf_a),
        .divisor   (rf_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        logic [31:0] w, imm, immz, a, b, pcn, btgt, jtgt, ea, link, vec, sum;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh;
        logic        iso, ex_en, br_en, wr_en, push_en, ld_go, ages, found;
        logic [4:0]  ex_code, wr_addr, push_tgt;
        logic [31:0] br_tgt, wr_data, push_val, dv;

        w = ir_reg.instr_word;
        op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
        sh = w[10:6]; fn = w[5:0];
        immz = {16'd0, w[15:0]};
        imm  = {{16{w[15]}}, w[15:0]};
        a = rf_a; b = rf_b;
        pcn  = pc_after_reg;
        btgt = pcn + {imm[29:0], 2'b00};
        jtgt = {pcn[31:28], w[25:0], 2'b00};
        link = pcn + 32'd4;
        ea   = a + imm;
        sum  = 32'd0;
        iso  = status_reg[mr3k_pkg::ISOLATE_POS];
        vec  = status_reg[mr3k_pkg::BEV_POS] ? mr3k_pkg::ROM_VECTOR : mr3k_pkg::RAM_VECTOR;
        ex_en = 1'b0; ex_code = '0; br_en = 1'b0; br_tgt = '0;
        wr_en = 1'b0; wr_addr = '0; wr_data = '0;
        push_en = 1'b0; push_tgt = '0; push_val = '0;
        ld_go = 1'b0; ages = 1'b1; found = 1'b0; dv = '0;

        state_next     = state_reg;
        ir_next        = ir_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        hi_next = hi_reg; lo_next = lo_reg;
        pc_now_next = pc_now_reg; pc_after_next = pc_after_reg;
        exec_pc_next = exec_pc_reg; br_next = br_reg; dly_next = dly_reg;
        status_next = status_reg; cause_next = cause_reg; epc_next = epc_reg;
        wait_next = wait_reg; wait_kind_next = wait_kind_reg; wait_tgt_next = wait_tgt_reg;
        for (int i = 0; i < LOAD_SLOTS; i++)
        begin
            ld_tgt_next[i] = ld_tgt_reg[i];
            ld_val_next[i] = ld_val_reg[i];
            ld_age_next[i] = ld_age_reg[i];
            ld_vld_next[i] = ld_vld_reg[i];
        end
        rf_wr     = '0;
        div_start = 1'b0;
        div_sgn   = (fn == mr3k_pkg::FN_DIV);

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    ir_next  = item;
                    res_next = '0;
                    if ((item.cmd == mr3k_pkg::CMD_INSTR && !wait_reg) ||
                        (item.cmd == mr3k_pkg::CMD_DATA && wait_reg))
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_READ:
            begin
                state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                if (ir_reg.cmd == mr3k_pkg::CMD_DATA)
                begin
                    unique case (wait_kind_reg)
                        mr3k_pkg::LD_LW:  dv = ir_reg.read_data;
                        mr3k_pkg::LD_LBU: dv = {24'd0, ir_reg.read_data[7:0]};
                        default:          dv = {{24{ir_reg.read_data[7]}},
                                                ir_reg.read_data[7:0]};
                    endcase
                    push_en = 1'b1; push_tgt = wait_tgt_reg; push_val = dv;
                    wait_next = 1'b0; wait_kind_next = '0; wait_tgt_next = '0;
                end
                else
                begin
                    exec_pc_next = pc_now_reg;
                    dly_next     = br_reg;
                    br_next      = 1'b0;
                    if (pc_now_reg[1:0] != 2'b00)
                    begin
                        ex_en = 1'b1; ex_code = mr3k_pkg::EXC_ADEL; ages = 1'b0;
                    end
                    else
                    begin
                        pc_now_next   = pcn;
                        pc_after_next = pc_after_reg + 32'd4;
                        unique case (op)
                            mr3k_pkg::OP_SPECIAL:
                            begin
                                unique case (fn)
                                    mr3k_pkg::FN_SLL:
                                    begin wr_en = 1'b1; wr_addr = rd; wr_data = b << sh; end
                                    mr3k_pkg::FN_SRL:
                                    begin wr_en = 1'b1; wr_addr = rd; wr_data = b >> sh; end
                                    mr3k_pkg::FN_SRA:
                                    begin
                                        wr_en = 1'b1; wr_addr = rd;
                                        wr_data = $unsigned($signed(b) >>> sh);
                                    end
                                    mr3k_pkg::FN_JR:
                                    begin br_en = 1'b1; br_tgt = a; end
                                    mr3k_pkg::FN_JALR:
                                    begin
                                        wr_en = 1'b1; wr_addr = rd; wr_data = link;
                                        br_en = 1'b1; br_tgt = a;
                                    end
                                    mr3k_pkg::FN_SYSCALL:
                                    begin ex_en = 1'b1; ex_code = mr3k_pkg::EXC_SYS; end
                                    mr3k_pkg::FN_MFHI:
                                    begin wr_en = 1'b1; wr_addr = rd; wr_data = hi_reg; end
                                    mr3k_pkg::FN_MTHI: hi_next = a;
                                    mr3k_pkg::FN_MFLO:
                                    begin wr_en = 1'b1; wr_addr = rd; wr_data = lo_reg; end
                                    mr3k_pkg::FN_MTLO: lo_next = a;
                                    mr3k_pkg::FN_DIV, mr3k_pkg::FN_DIVU:
                                    begin
                                        if (b == 32'd0)
                                        begin
                                            hi_next = a;
                                            lo_next = (div_sgn && a[31]) ? 32'd1 : 32'hFFFF_FFFF;
                                        end
                                        else
                                        begin
                                            div_start = 1'b1;
                                        end
                                    end
                                    mr3k_pkg::FN_ADD:
                                    begin
                                        sum = a + b;
                                        if (~(a[31] ^ b[31]) & (a[31] ^ sum[31]))
                                        begin
                                            ex_en = 1'b1; ex_code = mr3k_pkg::EXC_OV;
                                        end
                                        else
                                        begin
                                            wr_en = 1'b1; wr_addr = rd; wr_data = sum;
                                        end
                                    end
                                    mr3k_pkg::FN_ADDU:
                                    begin wr_en = 1'b1; wr_addr = rd; wr_data = a + b; end
                                    mr3k_pkg::FN_SUBU:
                                    begin wr_en = 1'b1; wr_addr = rd; wr_data = a - b; end
                                    mr3k_pkg::FN_AND:
                                    begin wr_en = 1'b1; wr_addr = rd; wr_data = a & b; end
                                    mr3k_pkg::FN_OR:
                                    begin wr_en = 1'b1; wr_addr = rd; wr_data = a | b; end
                                    mr3k_pkg::FN_XOR:
                                    begin wr_en = 1'b1; wr_addr = rd; wr_data = a ^ b; end
                                    mr3k_pkg::FN_NOR:
                                    begin wr_en = 1'b1; wr_addr = rd; wr_data = ~(a | b); end
                                    mr3k_pkg::FN_SLT:
                                    begin
                                        wr_en = 1'b1; wr_addr = rd;
                                        wr_data = {31'd0, $signed(a) < $signed(b)};
                                    end
                                    mr3k_pkg::FN_SLTU:
                                    begin
                                        wr_en = 1'b1; wr_addr = rd; wr_data = {31'd0, a < b};
                                    end
                                    default: res_next.illegal = 1'b1;
                                endcase
                            end
                            mr3k_pkg::OP_REGIMM:
                            begin
                                if (rt == mr3k_pkg::RI_BLTZ || rt == mr3k_pkg::RI_BGEZ ||
                                    rt == mr3k_pkg::RI_BLTZAL || rt == mr3k_pkg::RI_BGEZAL)
                                begin
                                    if (rt[4])
                                    begin
                                        wr_en = 1'b1; wr_addr = mr3k_pkg::LINK_REG;
                                        wr_data = link;
                                    end
                                    if (rt[0] ? !a[31] : a[31])
                                    begin
                                        br_en = 1'b1; br_tgt = btgt;
                                    end
                                end
                                else
                                begin
                                    res_next.illegal = 1'b1;
                                end
                            end
                            mr3k_pkg::OP_J:
                            begin br_en = 1'b1; br_tgt = jtgt; end
                            mr3k_pkg::OP_JAL:
                            begin
                                wr_en = 1'b1; wr_addr = mr3k_pkg::LINK_REG; wr_data = link;
                                br_en = 1'b1; br_tgt = jtgt;
                            end
                            mr3k_pkg::OP_BEQ:
                            begin br_en = (a == b); br_tgt = btgt; end
                            mr3k_pkg::OP_BNE:
                            begin br_en = (a != b); br_tgt = btgt; end
                            mr3k_pkg::OP_BLEZ:
                            begin br_en = a[31] || (a == 32'd0); br_tgt = btgt; end
                            mr3k_pkg::OP_BGTZ:
                            begin br_en = !a[31] && (a != 32'd0); br_tgt = btgt; end
                            mr3k_pkg::OP_ADDI:
                            begin
                                sum = a + imm;
                                if (~(a[31] ^ imm[31]) & (a[31] ^ sum[31]))
                                begin
                                    ex_en = 1'b1; ex_code = mr3k_pkg::EXC_OV;
                                end
                                else
                                begin
                                    wr_en = 1'b1; wr_addr = rt; wr_data = sum;
                                end
                            end
                            mr3k_pkg::OP_ADDIU:
                            begin wr_en = 1'b1; wr_addr = rt; wr_data = a + imm; end
                            mr3k_pkg::OP_SLTI:
                            begin
                                wr_en = 1'b1; wr_addr = rt;
                                wr_data = {31'd0, $signed(a) < $signed(imm)};
                            end
                            mr3k_pkg::OP_SLTIU:
                            begin wr_en = 1'b1; wr_addr = rt; wr_data = {31'd0, a < imm}; end
                            mr3k_pkg::OP_ANDI:
                            begin wr_en = 1'b1; wr_addr = rt; wr_data = a & immz; end
                            mr3k_pkg::OP_ORI:
                            begin wr_en = 1'b1; wr_addr = rt; wr_data = a | immz; end
                            mr3k_pkg::OP_XORI:
                            begin wr_en = 1'b1; wr_addr = rt; wr_data = a ^ immz; end
                            mr3k_pkg::OP_LUI:
                            begin wr_en = 1'b1; wr_addr = rt; wr_data = {w[15:0], 16'd0}; end
                            mr3k_pkg::OP_COP0:
                            begin
                                if (rs == mr3k_pkg::CP_MF)
                                begin
                                    push_tgt = rt;
                                    push_en  = 1'b1;
                                    if (rd == mr3k_pkg::C0_STATUS) push_val = status_reg;
                                    else if (rd == mr3k_pkg::C0_CAUSE) push_val = cause_reg;
                                    else if (rd == mr3k_pkg::C0_EPC) push_val = epc_reg;
                                    else if (mr3k_pkg::c0_debug(rd)) push_val = '0;
                                    else
                                    begin
                                        push_en = 1'b0; res_next.illegal = 1'b1;
                                    end
                                end
                                else if (rs == mr3k_pkg::CP_MT)
                                begin
                                    if (rd == mr3k_pkg::C0_STATUS) status_next = b;
                                    else if (rd == mr3k_pkg::C0_CAUSE) cause_next = b;
                                    else if (rd == mr3k_pkg::C0_EPC) epc_next = b;
                                    else if (!mr3k_pkg::c0_debug(rd)) res_next.illegal = 1'b1;
                                end
                                else if (rs == mr3k_pkg::CP_CO && fn == mr3k_pkg::FN_RFE)
                                begin
                                    status_next = {status_reg[31:4], status_reg[5:2]};
                                end
                                else
                                begin
                                    res_next.illegal = 1'b1;
                                end
                            end
                            mr3k_pkg::OP_LB, mr3k_pkg::OP_LBU:
                            begin
                                if (!iso)
                                begin
                                    ld_go = 1'b1;
                                    res_next.req_kind = mr3k_pkg::REQ_READ;
                                    res_next.mem_addr = ea;
                                    res_next.mem_size = mr3k_pkg::SIZE_BYTE;
                                    wait_kind_next = (op == mr3k_pkg::OP_LBU) ?
                                                     mr3k_pkg::LD_LBU : mr3k_pkg::LD_LB;
                                end
                            end
                            mr3k_pkg::OP_LW:
                            begin
                                if (!iso)
                                begin
                                    if (ea[1:0] != 2'b00)
                                    begin
                                        ex_en = 1'b1; ex_code = mr3k_pkg::EXC_ADEL;
                                    end
                                    else
                                    begin
                                        ld_go = 1'b1;
                                        res_next.req_kind = mr3k_pkg::REQ_READ;
                                        res_next.mem_addr = ea;
                                        res_next.mem_size = mr3k_pkg::SIZE_WORD;
                                        wait_kind_next = mr3k_pkg::LD_LW;
                                    end
                                end
                            end
                            mr3k_pkg::OP_SB:
                            begin
                                if (!iso)
                                begin
                                    res_next.req_kind   = mr3k_pkg::REQ_WRITE;
                                    res_next.mem_addr   = ea;
                                    res_next.mem_size   = mr3k_pkg::SIZE_BYTE;
                                    res_next.write_data = {24'd0, b[7:0]};
                                end
                            end
                            mr3k_pkg::OP_SH:
                            begin
                                if (!iso)
                                begin
                                    if (ea[0])
                                    begin
                                        ex_en = 1'b1; ex_code = mr3k_pkg::EXC_ADES;
                                    end
                                    else
                                    begin
                                        res_next.req_kind   = mr3k_pkg::REQ_WRITE;
                                        res_next.mem_addr   = ea;
                                        res_next.mem_size   = mr3k_pkg::SIZE_HALF;
                                        res_next.write_data = {16'd0, b[15:0]};
                                    end
                                end
                            end
                            mr3k_pkg::OP_SW:
                            begin
                                if (!iso)
                                begin
                                    if (ea[1:0] != 2'b00)
                                    begin
                                        ex_en = 1'b1; ex_code = mr3k_pkg::EXC_ADES;
                                    end
                                    else
                                    begin
                                        res_next.req_kind   = mr3k_pkg::REQ_WRITE;
                                        res_next.mem_addr   = ea;
                                        res_next.mem_size   = mr3k_pkg::SIZE_WORD;
                                        res_next.write_data = b;
                                    end
                                end
                            end
                            default: res_next.illegal = 1'b1;
                        endcase
                        if (ld_go)
                        begin
                            wait_next = 1'b1; wait_tgt_next = rt; ages = 1'b0;
                        end
                        if (br_en)
                        begin
                            pc_after_next = br_tgt; br_next = 1'b1;
                        end
                    end
                    if (ex_en)
                    begin
                        status_next = {status_reg[31:6], status_reg[3:0], 2'b00};
                        cause_next  = {br_reg, 24'd0, ex_code, 2'b00};
                        epc_next    = br_reg ? (pc_now_reg - 32'd4) : pc_now_reg;
                        pc_now_next   = vec;
                        pc_after_next = vec + 32'd4;
                        res_next.exception_taken = 1'b1;
                        res_next.exception_code  = ex_code;
                    end
                end

                // a register write cancels a pending load to the same target
                if (wr_en)
                begin
                    for (int i = 0; i < LOAD_SLOTS; i++)
                    begin
                        if (ld_vld_reg[i] && !ld_age_reg[i] && ld_tgt_reg[i] == wr_addr)
                        begin
                            ld_vld_next[i] = 1'b0;
                        end
                    end
                    rf_wr.en   = (wr_addr != 5'd0);
                    rf_wr.addr = wr_addr;
                    rf_wr.data = wr_data;
                end
                if (push_en)
                begin
                    for (int i = 0; i < LOAD_SLOTS; i++)
                    begin
                        if (!found && !ld_vld_reg[i])
                        begin
                            found = 1'b1;
                            ld_vld_next[i] = 1'b1;
                            ld_tgt_next[i] = push_tgt;
                            ld_val_next[i] = push_val;
                            ld_age_next[i] = 1'b1;
                        end
                    end
                end
                if (div_start)
                    state_next = ST_DIV;
                else if (ages)
                    state_next = ST_AGE;
                else
                    state_next = ST_DONE;
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    hi_next    = div_r;
                    lo_next    = div_q;
                    state_next = ST_AGE;
                end
            end

            ST_AGE:
            begin
                // retire one aged load per cycle, then age the rest
                for (int i = 0; i < LOAD_SLOTS; i++)
                begin
                    if (!found && ld_vld_reg[i] && !ld_age_reg[i])
                    begin
                        found = 1'b1;
                        ld_vld_next[i] = 1'b0;
                        rf_wr.en   = (ld_tgt_reg[i] != 5'd0);
                        rf_wr.addr = ld_tgt_reg[i];
                        rf_wr.data = ld_val_reg[i];
                        wr_addr    = ld_tgt_reg[i];
                    end
                end
                if (found)
                begin
                    for (int i = 0; i < LOAD_SLOTS; i++)
                    begin
                        if (ld_vld_reg[i] && !ld_age_reg[i] && ld_tgt_reg[i] == wr_addr)
                        begin
                            ld_vld_next[i] = 1'b0;
                        end
                    end
                end
                else
                begin
                    for (int i = 0; i < LOAD_SLOTS; i++)
                    begin
                        if (ld_vld_reg[i])
                        begin
                            ld_age_next[i] = 1'b0;
                        end
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next            = res_reg;
                    out_next.fetch_addr = pc_now_reg;
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            hi_reg        <= mr3k_pkg::FILL_WORD;
            lo_reg        <= mr3k_pkg::FILL_WORD;
            pc_now_reg    <= mr3k_pkg::BOOT_PC;
            pc_after_reg  <= mr3k_pkg::BOOT_PC + 32'd4;
            exec_pc_reg   <= mr3k_pkg::BOOT_PC;
            br_reg        <= 1'b0;
            dly_reg       <= 1'b0;
            status_reg    <= '0;
            cause_reg     <= '0;
            epc_reg       <= '0;
            wait_reg      <= 1'b0;
            wait_kind_reg <= '0;
            wait_tgt_reg  <= '0;
            for (int i = 0; i < LOAD_SLOTS; i++)
            begin
                ld_tgt_reg[i] <= '0;
                ld_val_reg[i] <= '0;
                ld_age_reg[i] <= 1'b0;
                ld_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            pc_now_reg    <= pc_now_next;
            pc_after_reg  <= pc_after_next;
            exec_pc_reg   <= exec_pc_next;
            br_reg        <= br_next;
            dly_reg       <= dly_next;
            status_reg    <= status_next;
            cause_reg     <= cause_next;
            epc_reg       <= epc_next;
            wait_reg      <= wait_next;
            wait_kind_reg <= wait_kind_next;
            wait_tgt_reg  <= wait_tgt_next;
            for (int i = 0; i < LOAD_SLOTS; i++)
            begin
                ld_tgt_reg[i] <= ld_tgt_next[i];
                ld_val_reg[i] <= ld_val_next[i];
                ld_age_reg[i] <= ld_age_next[i];
                ld_vld_reg[i] <= ld_vld_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ir_reg  <= ir_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

endmodule
